[sv/nested_tag_strip_char_filter_assert.svh]
// Assertion macros for the nested tag strip character filter.
`ifndef NESTED_TAG_STRIP_CHAR_FILTER_ASSERT_SVH
`define NESTED_TAG_STRIP_CHAR_FILTER_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define NTSCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies the consequent in the same cycle.
`define NTSCF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/ntscf_pkg.sv]
// Package with constants, state type and helpers of the nested tag strip filter.
package ntscf_pkg;

	localparam int DEPTH_WIDTH = 8;
	localparam int CHAR_WIDTH  = 16;
	localparam int MASK_WIDTH  = 7;

	localparam logic [DEPTH_WIDTH-1:0] DEPTH_MAX = {DEPTH_WIDTH{1'b1}};
	localparam logic [DEPTH_WIDTH-1:0] DEPTH_ZERO = '0;

	// Enable bit positions in the strip mask.
	localparam int BIT_SQUARE = 0;
	localparam int BIT_ANGLE  = 1;
	localparam int BIT_CURLY  = 2;
	localparam int BIT_PAREN  = 3;
	localparam int BIT_SLASH  = 4;
	localparam int BIT_PIPE   = 5;
	localparam int BIT_HASH   = 6;

	// Character codes.
	localparam logic [CHAR_WIDTH-1:0] CH_SQ_OPEN  = 16'h005B;
	localparam logic [CHAR_WIDTH-1:0] CH_SQ_CLOSE = 16'h005D;
	localparam logic [CHAR_WIDTH-1:0] CH_AN_OPEN  = 16'h003C;
	localparam logic [CHAR_WIDTH-1:0] CH_AN_CLOSE = 16'h003E;
	localparam logic [CHAR_WIDTH-1:0] CH_CU_OPEN  = 16'h007B;
	localparam logic [CHAR_WIDTH-1:0] CH_CU_CLOSE = 16'h007D;
	localparam logic [CHAR_WIDTH-1:0] CH_PA_OPEN  = 16'h0028;
	localparam logic [CHAR_WIDTH-1:0] CH_PA_CLOSE = 16'h0029;
	localparam logic [CHAR_WIDTH-1:0] CH_SLASH    = 16'h002F;
	localparam logic [CHAR_WIDTH-1:0] CH_PIPE     = 16'h007C;
	localparam logic [CHAR_WIDTH-1:0] CH_HASH     = 16'h0023;
	localparam logic [CHAR_WIDTH-1:0] CH_SPACE    = 16'h0020;
	localparam logic [CHAR_WIDTH-1:0] CH_LF       = 16'h000A;
	localparam logic [CHAR_WIDTH-1:0] CH_CR       = 16'h000D;
	localparam logic [CHAR_WIDTH-1:0] CH_TAB      = 16'h0009;

	typedef struct packed {
		logic [DEPTH_WIDTH-1:0] square_depth;
		logic [DEPTH_WIDTH-1:0] angle_depth;
		logic [DEPTH_WIDTH-1:0] curly_depth;
		logic [DEPTH_WIDTH-1:0] paren_depth;
		logic                   in_slash;
		logic                   in_pipe;
		logic                   in_hash;
		logic                   eat_space;
	} tag_state_t;

	localparam tag_state_t STATE_CLEAR = '0;

	// True while any tag is open.
	function automatic logic inside_any(input tag_state_t st);
		return (st.square_depth != DEPTH_ZERO) || (st.angle_depth != DEPTH_ZERO) ||
		       (st.curly_depth != DEPTH_ZERO) || (st.paren_depth != DEPTH_ZERO) ||
		       st.in_slash || st.in_pipe || st.in_hash;
	endfunction

	// Saturating increment of a depth counter.
	function automatic logic [DEPTH_WIDTH-1:0] depth_inc(input logic [DEPTH_WIDTH-1:0] d);
		return (d == DEPTH_MAX) ? d : d + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [CHAR_WIDTH-1:0] c);
		return (c == CH_SPACE) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
	endfunction

endpackage

[sv/nested_tag_strip_char_filter.sv]
// Top level of the nested tag strip character filter.
// Output: a kept word appears on the master side in the cycle after it is accepted.
// Throughput: one word per cycle; the tag state updates in the accepting cycle and
// the output register takes the next word whenever it is empty or being drained.
// Reset: arst_n clears the strip mask, all depth counters, toggles, the eat flag
// and the output valid at once; no clearing pass is needed.
module nested_tag_strip_char_filter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration: strip_mask write.
	input  logic                                 cfg_we,
	input  logic [ntscf_pkg::MASK_WIDTH-1:0]     cfg_data,
	// Slave side.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ntscf_pkg::CHAR_WIDTH-1:0]     s_tdata,  // [15:0] char_code
	input  logic                                 s_tuser,  // [0] clear_first
	// Master side.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ntscf_pkg::CHAR_WIDTH-1:0]     m_tdata   // [15:0] out_char
);

	logic [ntscf_pkg::MASK_WIDTH-1:0] strip_mask_q;
	ntscf_pkg::tag_state_t            state_q;
	ntscf_pkg::tag_state_t            state_eff;
	ntscf_pkg::tag_state_t            state_nxt;
	logic                             out_valid_q;
	logic [ntscf_pkg::CHAR_WIDTH-1:0] out_char_q;
	logic                             in_accept;
	logic                             consumed;
	logic                             closed;
	logic                             emit;

	// The output register acts as the stage boundary: a new word is taken
	// whenever the register is empty or its content leaves in this cycle.
	assign s_tready  = !out_valid_q || m_tready;
	assign in_accept = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_char_q;

	// The clear bit starts a new message: the state is zeroed before the word.
	assign state_eff = s_tuser ? ntscf_pkg::STATE_CLEAR : state_q;

	// Delimiter decoding in priority order: square, angle, curly, paren, then
	// the three toggles. A closer only counts while its pair is open.
	always_comb begin
		state_nxt = state_eff;
		consumed  = 1'b1;
		closed    = 1'b0;
		emit      = 1'b0;
		if (strip_mask_q[ntscf_pkg::BIT_SQUARE] && s_tdata == ntscf_pkg::CH_SQ_OPEN) begin
			state_nxt.square_depth = ntscf_pkg::depth_inc(state_eff.square_depth);
		end else if (strip_mask_q[ntscf_pkg::BIT_SQUARE] && s_tdata == ntscf_pkg::CH_SQ_CLOSE
		             && state_eff.square_depth != ntscf_pkg::DEPTH_ZERO) begin
			state_nxt.square_depth = state_eff.square_depth - 1'b1;
			closed = 1'b1;
		end else if (strip_mask_q[ntscf_pkg::BIT_ANGLE] && s_tdata == ntscf_pkg::CH_AN_OPEN) begin
			state_nxt.angle_depth = ntscf_pkg::depth_inc(state_eff.angle_depth);
		end else if (strip_mask_q[ntscf_pkg::BIT_ANGLE] && s_tdata == ntscf_pkg::CH_AN_CLOSE
		             && state_eff.angle_depth != ntscf_pkg::DEPTH_ZERO) begin
			state_nxt.angle_depth = state_eff.angle_depth - 1'b1;
			closed = 1'b1;
		end else if (strip_mask_q[ntscf_pkg::BIT_CURLY] && s_tdata == ntscf_pkg::CH_CU_OPEN) begin
			state_nxt.curly_depth = ntscf_pkg::depth_inc(state_eff.curly_depth);
		end else if (strip_mask_q[ntscf_pkg::BIT_CURLY] && s_tdata == ntscf_pkg::CH_CU_CLOSE
		             && state_eff.curly_depth != ntscf_pkg::DEPTH_ZERO) begin
			state_nxt.curly_depth = state_eff.curly_depth - 1'b1;
			closed = 1'b1;
		end else if (strip_mask_q[ntscf_pkg::BIT_PAREN] && s_tdata == ntscf_pkg::CH_PA_OPEN) begin
			state_nxt.paren_depth = ntscf_pkg::depth_inc(state_eff.paren_depth);
		end else if (strip_mask_q[ntscf_pkg::BIT_PAREN] && s_tdata == ntscf_pkg::CH_PA_CLOSE
		             && state_eff.paren_depth != ntscf_pkg::DEPTH_ZERO) begin
			state_nxt.paren_depth = state_eff.paren_depth - 1'b1;
			closed = 1'b1;
		end else if (strip_mask_q[ntscf_pkg::BIT_SLASH] && s_tdata == ntscf_pkg::CH_SLASH) begin
			state_nxt.in_slash = !state_eff.in_slash;
			closed = state_eff.in_slash;
		end else if (strip_mask_q[ntscf_pkg::BIT_PIPE] && s_tdata == ntscf_pkg::CH_PIPE) begin
			state_nxt.in_pipe = !state_eff.in_pipe;
			closed = state_eff.in_pipe;
		end else if (strip_mask_q[ntscf_pkg::BIT_HASH] && s_tdata == ntscf_pkg::CH_HASH) begin
			state_nxt.in_hash = !state_eff.in_hash;
			closed = state_eff.in_hash;
		end else begin
			consumed = 1'b0;
		end

		if (consumed) begin
			// Closing the last open tag arms the eat flag; a nested close does not.
			if (closed && !ntscf_pkg::inside_any(state_nxt)) begin
				state_nxt.eat_space = 1'b1;
			end
		end else if (!ntscf_pkg::inside_any(state_eff)) begin
			// First word outside all tags: the eat flag is spent either way and
			// only a blank is swallowed.
			if (state_eff.eat_space) begin
				state_nxt.eat_space = 1'b0;
				emit = !ntscf_pkg::is_blank(s_tdata);
			end else begin
				emit = 1'b1;
			end
		end
	end

	// Control registers: mask, tag state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_mask_q <= '0;
			state_q      <= ntscf_pkg::STATE_CLEAR;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				strip_mask_q <= cfg_data;
			end
			if (in_accept) begin
				state_q     <= state_nxt;
				out_valid_q <= emit;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload register, loaded only with a kept word.
	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			out_char_q <= s_tdata;
		end
	end

`include "nested_tag_strip_char_filter_assert.svh"

	// A clear bit resets every tag, so a plain letter right after it must pass.
	`NTSCF_ASSERT_NEXT(a_clear_passes_letter,
		in_accept && s_tuser && s_tdata == 16'h0041,
		m_tvalid && m_tdata == 16'h0041,
		"letter after clear was not passed")

	// An enabled square opener is always dropped.
	`NTSCF_ASSERT_NEXT(a_opener_dropped,
		in_accept && strip_mask_q[ntscf_pkg::BIT_SQUARE] && s_tdata == ntscf_pkg::CH_SQ_OPEN,
		!m_tvalid,
		"enabled square opener reached the output")

	// While a square tag stays open, a word that is no delimiter produces nothing.
	`NTSCF_ASSERT_SAME(a_inside_no_emit,
		in_accept && !s_tuser && state_q.square_depth != ntscf_pkg::DEPTH_ZERO &&
		s_tdata == 16'h0041,
		!emit,
		"word inside an open tag was kept")

endmodule

[tb/tb.sv]
// Self-checking testbench for the nested tag strip character filter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ntscf_pkg::*;

	// One character waiting to be offered on the slave side.
	typedef struct {
		logic [CHAR_WIDTH-1:0] code;
		bit                    clr;
	} char_word_t;

	// Delimiter kinds, in the order of their enable bits.
	typedef enum int {
		DK_SQUARE, DK_ANGLE, DK_CURLY, DK_PAREN, DK_SLASH, DK_PIPE, DK_HASH
	} delim_kind_e;

	localparam int NUM_PAIRS  = 4;
	localparam int NUM_KINDS  = 7;
	localparam int RAND_ITEMS = 1150;
	localparam int PHASE_LEN  = 175;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [MASK_WIDTH-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [CHAR_WIDTH-1:0] s_tdata = '0;   // [15:0] char_code
	logic                  s_tuser = 1'b0; // [0] clear_first
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [CHAR_WIDTH-1:0] m_tdata;        // [15:0] out_char

	// Characters still to be offered, and kept characters still to come out.
	char_word_t            feed_q[$];
	logic [CHAR_WIDTH-1:0] kept_q[$];

	// Private copy of the filter state and of the strip mask.
	logic [DEPTH_WIDTH-1:0] depth_r [NUM_PAIRS];
	bit [2:0]               toggle_r = '0;
	bit                     eat_armed = 1'b0;
	logic [MASK_WIDTH-1:0]  mask_m = '0;

	int n_queued = 0;
	int n_accepted = 0;
	int n_clears = 0;
	int n_kept = 0;
	int n_masks = 0;
	int n_fail = 0;
	int feed_gap = 0;
	int feed_calm = 0;
	int sink_stall = 0;
	int sink_calm = 0;

	always #5 clk = ~clk;

	nested_tag_strip_char_filter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Character of a delimiter kind; toggles use the same character both ways.
	function automatic logic [CHAR_WIDTH-1:0] delim_char(input int kind, input bit closing);
		case (kind)
			DK_SQUARE: return closing ? CH_SQ_CLOSE : CH_SQ_OPEN;
			DK_ANGLE:  return closing ? CH_AN_CLOSE : CH_AN_OPEN;
			DK_CURLY:  return closing ? CH_CU_CLOSE : CH_CU_OPEN;
			DK_PAREN:  return closing ? CH_PA_CLOSE : CH_PA_OPEN;
			DK_SLASH:  return CH_SLASH;
			DK_PIPE:   return CH_PIPE;
			default:   return CH_HASH;
		endcase
	endfunction

	function automatic int mask_pos(input int kind);
		case (kind)
			DK_SQUARE: return BIT_SQUARE;
			DK_ANGLE:  return BIT_ANGLE;
			DK_CURLY:  return BIT_CURLY;
			DK_PAREN:  return BIT_PAREN;
			DK_SLASH:  return BIT_SLASH;
			DK_PIPE:   return BIT_PIPE;
			default:   return BIT_HASH;
		endcase
	endfunction

	function automatic bit any_open();
		bit open_seen;
		open_seen = (toggle_r != 3'b000);
		for (int k = 0; k < NUM_PAIRS; k++)
			if (depth_r[k] != '0)
				open_seen = 1'b1;
		return open_seen;
	endfunction

	// Advances the private filter state by one character; returns 1 if the
	// character is kept. Pairs are tried before toggles, in enable bit order.
	function automatic bit filter_char(input logic [CHAR_WIDTH-1:0] c, input bit clr);
		bit hit;
		hit = 1'b0;
		if (clr) begin
			for (int k = 0; k < NUM_PAIRS; k++)
				depth_r[k] = '0;
			toggle_r = '0;
			eat_armed = 1'b0;
		end
		for (int k = DK_SQUARE; k <= DK_PAREN; k++) begin
			if (!hit && mask_m[mask_pos(k)]) begin
				if (c == delim_char(k, 1'b0)) begin
					// The counter sticks at its top value; the opener is dropped anyway.
					if (depth_r[k] != DEPTH_MAX)
						depth_r[k] = depth_r[k] + 1'b1;
					hit = 1'b1;
				end else if (c == delim_char(k, 1'b1) && depth_r[k] != '0) begin
					depth_r[k] = depth_r[k] - 1'b1;
					hit = 1'b1;
					if (!any_open())
						eat_armed = 1'b1;
				end
			end
		end
		for (int k = DK_SLASH; k <= DK_HASH; k++) begin
			if (!hit && mask_m[mask_pos(k)] && c == delim_char(k, 1'b0)) begin
				toggle_r[k - DK_SLASH] = !toggle_r[k - DK_SLASH];
				hit = 1'b1;
				if (!toggle_r[k - DK_SLASH] && !any_open())
					eat_armed = 1'b1;
			end
		end
		if (hit || any_open())
			return 1'b0;
		// The first character outside all tags after a close disarms the eat flag.
		if (eat_armed) begin
			eat_armed = 1'b0;
			if (c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Idle length for either side: mostly none or short, a few long, and now
	// and then a calm stretch with no idling at all.
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 199);
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 110)
			return 0;
		if (r < 175)
			return $urandom_range(1, 3);
		if (r < 195)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Driver: offers the head of feed_q and predicts each word as it is taken.
	always @(posedge clk) begin : feed_drive
		char_word_t taken;
		bit         offer;
		if (arst_n) begin
			offer = s_tvalid;
			if (s_tvalid && s_tready) begin
				taken = feed_q.pop_front();
				n_accepted++;
				if (taken.clr)
					n_clears++;
				if (filter_char(taken.code, taken.clr))
					kept_q.push_back(taken.code);
				feed_gap = next_gap(feed_calm);
				offer = 1'b0;
			end
			// A word on offer is held until taken; otherwise a gap may run first.
			if (!offer) begin
				if (feed_gap > 0) begin
					feed_gap--;
				end else if (feed_q.size() > 0) begin
					offer = 1'b1;
					s_tdata <= feed_q[0].code;
					s_tuser <= feed_q[0].clr;
				end
			end
			s_tvalid <= offer;
		end
	end

	// Monitor: checks every kept word against the oldest prediction and stalls
	// the master side at random.
	always @(posedge clk) begin : kept_check
		logic [CHAR_WIDTH-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				n_kept++;
				if (kept_q.size() == 0) begin
					$error("out_char: no word expected, actual %h", m_tdata);
					n_fail++;
				end else begin
					want = kept_q.pop_front();
					if (m_tdata !== want) begin
						$error("out_char: expected %h, actual %h", want, m_tdata);
						n_fail++;
					end
				end
			end
			if (sink_stall > 0)
				sink_stall--;
			else
				sink_stall = next_gap(sink_calm);
			m_tready <= (sink_stall == 0);
		end
	end

	task automatic push_char(input logic [CHAR_WIDTH-1:0] c, input bit clr);
		char_word_t w;
		w.code = c;
		w.clr = clr;
		feed_q.push_back(w);
		n_queued++;
	endtask

	// Waits until every queued word is taken and every kept word is out, then waits
	// on in case the last word taken was dropped.
	task automatic settle();
		while (feed_q.size() != 0 || s_tvalid || kept_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mask writes happen only with the filter idle.
	task automatic write_mask(input logic [MASK_WIDTH-1:0] v);
		settle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mask_m = v;
		n_masks++;
		@(negedge clk);
	endtask

	function automatic logic [CHAR_WIDTH-1:0] pick_text();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 16'h0061 + 16'($urandom_range(0, 25));
		if (r < 65) begin
			case ($urandom_range(0, 3))
				0:       return CH_SPACE;
				1:       return CH_LF;
				2:       return CH_CR;
				default: return CH_TAB;
			endcase
		end
		if (r < 80)
			return 16'($urandom_range(0, 65535));
		if (r < 90)
			return delim_char(int'($urandom_range(0, NUM_KINDS - 1)),
				1'($urandom_range(0, 1)));
		return 16'($urandom_range(16'h0020, 16'h007E));
	endfunction

	// A tag with random content, sometimes nested, and now and then left open.
	task automatic gen_tag(input int lvl);
		int kind;
		kind = $urandom_range(0, NUM_KINDS - 1);
		push_char(delim_char(kind, 1'b0), 1'b0);
		repeat ($urandom_range(0, 4)) push_char(pick_text(), 1'b0);
		if (lvl < 2 && $urandom_range(0, 2) == 0)
			gen_tag(lvl + 1);
		repeat ($urandom_range(0, 2)) push_char(pick_text(), 1'b0);
		if ($urandom_range(0, 9) != 0)
			push_char(delim_char(kind, 1'b1), 1'b0);
	endtask

	// One message: starts with a clear, then text runs, tags and blank runs;
	// a few messages are plain noise with stray clears.
	task automatic gen_message();
		int r;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(4, 12))
				push_char($urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) :
					delim_char(int'($urandom_range(0, NUM_KINDS - 1)),
						1'($urandom_range(0, 1))),
					$urandom_range(0, 15) == 0);
			return;
		end
		push_char(pick_text(), 1'b1);
		repeat ($urandom_range(1, 6)) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				gen_tag(0);
				if ($urandom_range(0, 9) < 4)
					push_char(r[0] ? CH_SPACE : CH_LF, 1'b0);
			end else begin
				repeat ($urandom_range(1, 5)) push_char(pick_text(), 1'b0);
			end
		end
	endtask

	initial begin : stimulus
		int rand_start;
		int phase;
		int i;
		for (int k = 0; k < NUM_PAIRS; k++)
			depth_r[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words, all delimiters enabled.
		write_mask('1);
		push_char(16'h0000, 1'b1);
		push_char(16'hFFFF, 1'b0);
		push_char(CH_SQ_OPEN, 1'b0);  push_char(16'("a"), 1'b0); push_char(CH_SQ_CLOSE, 1'b0);
		push_char(CH_SPACE, 1'b0);    push_char(CH_SPACE, 1'b0);
		// Nested close: the inner close leaves the eat flag alone.
		push_char(CH_AN_OPEN, 1'b0);  push_char(CH_PA_OPEN, 1'b0); push_char(16'("x"), 1'b0);
		push_char(CH_PA_CLOSE, 1'b0); push_char(CH_AN_CLOSE, 1'b0); push_char(CH_TAB, 1'b0);
		// Closer with nothing open passes as text.
		push_char(CH_SQ_CLOSE, 1'b0);
		push_char(CH_CU_OPEN, 1'b0);  push_char(CH_CU_CLOSE, 1'b0); push_char(CH_CR, 1'b0);
		push_char(CH_SLASH, 1'b0);    push_char(16'("q"), 1'b0); push_char(CH_SLASH, 1'b0);
		push_char(CH_LF, 1'b0);
		push_char(CH_PIPE, 1'b0);     push_char(CH_PIPE, 1'b0); push_char(16'("k"), 1'b0);
		push_char(CH_SPACE, 1'b0);
		// The eat flag armed by the hash close is dropped by the clear.
		push_char(CH_HASH, 1'b0);     push_char(CH_HASH, 1'b0); push_char(CH_SPACE, 1'b1);

		// Enable bits dropped while tags are open: the tags stay open.
		push_char(CH_SQ_OPEN, 1'b1);  push_char(CH_SLASH, 1'b0); push_char(16'("a"), 1'b0);
		write_mask('0);
		push_char(16'("b"), 1'b0); push_char(CH_SQ_CLOSE, 1'b0); push_char(CH_SLASH, 1'b0);
		write_mask('1);
		push_char(CH_SLASH, 1'b0); push_char(CH_SPACE, 1'b0); push_char(CH_SQ_CLOSE, 1'b0);
		push_char(CH_SPACE, 1'b0); push_char(16'("d"), 1'b0);

		// Saturation: more openers than the counter holds, then closers down
		// from the top value.
		push_char(CH_PA_OPEN, 1'b1);
		for (i = 0; i < (1 << DEPTH_WIDTH) + 20; i++)
			push_char(CH_SQ_OPEN, 1'b0);
		for (i = 0; i < int'(DEPTH_MAX) - 1; i++)
			push_char(CH_SQ_CLOSE, 1'b0);
		push_char(16'("z"), 1'b0); push_char(CH_PA_CLOSE, 1'b0); push_char(16'("y"), 1'b0);
		push_char(CH_SQ_CLOSE, 1'b0); push_char(CH_SPACE, 1'b0); push_char(16'("w"), 1'b0);

		// Random messages over a series of mask settings, extremes first.
		rand_start = n_queued;
		phase = 0;
		while (n_queued - rand_start < RAND_ITEMS) begin
			case (phase)
				0:       write_mask('1);
				1:       write_mask('0);
				2:       write_mask(7'h0F);
				3:       write_mask(7'h70);
				default: write_mask(MASK_WIDTH'($urandom_range(0, 127)));
			endcase
			i = n_queued;
			while (n_queued - i < PHASE_LEN)
				gen_message();
			phase++;
		end

		// Drain: everything taken, then a bounded wait for the last kept words.
		while (feed_q.size() != 0 || s_tvalid)
			@(negedge clk);
		for (i = 0; i < 1000 && kept_q.size() != 0; i++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (kept_q.size() != 0) begin
			$error("out_char: %0d kept words never came out, first expected %h",
				kept_q.size(), kept_q[0]);
			n_fail++;
		end

		$display("Run covered %0d characters (%0d with a clear) over %0d strip mask settings;",
			n_accepted, n_clears, n_masks);
		$display("%0d characters were kept and checked.", n_kept);
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop far beyond the slowest legal run.
	initial begin : watchdog
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
